FILE: src/sbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbt_pkg
// shared types and codes of the sorted breakpoint table
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int AddrWidth  = 16;
  localparam int CountWidth = 4;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } sbt_action_t;

  typedef struct packed {
    logic                  hit;
    logic [CountWidth-1:0] entry_count;
    logic                  rejected;
  } sbt_result_t;

endpackage

`default_nettype wire

FILE: src/sbt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbt_in_if / sbt_out_if
// valid/ready channels carrying request and result words
// ----------------------------------------------------------------------------
interface sbt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink (input valid, input action, input address, output ready);
endinterface

interface sbt_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [3:0] entry_count;
  logic       rejected;

  modport source (output valid, output hit, output entry_count, output rejected,
                  input ready);
  modport sink (input valid, input hit, input entry_count, input rejected,
                output ready);
endinterface

`default_nettype wire

FILE: src/sbt_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbt_mem
// address store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sbt_mem #(
  parameter int DEPTH = 15,
  parameter int AW    = 4
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [sbt_pkg::AddrWidth-1:0] wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [sbt_pkg::AddrWidth-1:0] rdata
);
  import sbt_pkg::*;

  logic [AddrWidth-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/sbt_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbt_out_reg
// result register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module sbt_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire sbt_pkg::sbt_result_t result,
  output logic                     free,
  sbt_out_if.source                rsp
);
  import sbt_pkg::*;

  logic        valid;
  sbt_result_t word;

  assign free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= result;
    end
  end

  assign rsp.valid       = valid;
  assign rsp.hit         = word.hit;
  assign rsp.entry_count = word.entry_count;
  assign rsp.rejected    = word.rejected;

endmodule

`default_nettype wire

FILE: src/sorted_breakpoint_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_breakpoint_table
// ascending multiset of nonzero breakpoint addresses with lookup/add/delete
// ----------------------------------------------------------------------------
// req carries one word per action (lookup, add, delete one copy, clear);
// rsp returns one word per request: hit, entry count after the action
// (low four bits) and rejected for an add to a full table.
// one request is worked at a time; req is ready only while the sequencer
// is idle, and a result waiting in the output register does not hold it.
// with n stored entries a binary search takes about log2(n+1) steps.
// lookup and delete search, then check the entry below the bound;
// delete then moves each later entry down one slot, and add searches,
// then moves each larger entry up one slot. clear, add of zero, full
// add and zero lookup/delete go straight to the result. the address
// memory has a single read port and registered read data: every
// probe needs a read, and every moved entry needs a read and a write.
// capacity is TABLE_SLOTS-1 entries. reset empties the table at once (the
// count is cleared, memory contents are never read above the count).
// a stalled rsp keeps the finished word; the sequencer waits in its
// final state until the output register is free.
// ----------------------------------------------------------------------------
module sorted_breakpoint_table #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  sbt_in_if.sink    req,
  sbt_out_if.source rsp
);
  import sbt_pkg::*;

  localparam int CAP = TABLE_SLOTS - 1;
  localparam int CW  = $clog2(TABLE_SLOTS);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SRCH_RD  = 7'b0000010,
    ST_SRCH_CMP = 7'b0000100,
    ST_PREV_CMP = 7'b0001000,
    ST_SHIFT_RD = 7'b0010000,
    ST_SHIFT_WR = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  state_t               state;
  sbt_action_t          act;
  logic [AddrWidth-1:0] key;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        count;
  logic                 hit;
  logic                 rej;

  logic [CW-1:0]        mid_calc;
  logic                 mem_we;
  logic [CW-1:0]        mem_waddr;
  logic [AddrWidth-1:0] mem_wdata;
  logic                 mem_re;
  logic [CW-1:0]        mem_raddr;
  logic [AddrWidth-1:0] mem_rdata;

  logic                 res_load;
  logic                 res_free;
  sbt_result_t          res;
  logic [CW+3:0]        count_wide;

  assign req.ready = (state == ST_IDLE);
  assign mid_calc  = lo + ((hi - lo) >> 1);
  assign res_load  = (state == ST_FINISH) && res_free;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = mid_calc;
    unique case (state)
      ST_SRCH_RD: begin
        if (lo < hi) begin
          mem_re = 1'b1;
        end else if (act != ACT_ADD && lo != '0) begin
          mem_re    = 1'b1;
          mem_raddr = lo - CW'(1);
        end
      end
      ST_SHIFT_RD: begin
        if (act == ACT_ADD) begin
          if (ptr == lo) begin
            mem_we    = 1'b1;
            mem_waddr = lo;
            mem_wdata = key;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr - CW'(1);
          end
        end else if (ptr != count - CW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = ptr + CW'(1);
        end
      end
      ST_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            act <= sbt_action_t'(req.action);
            key <= req.address;
            lo  <= '0;
            hi  <= count;
            hit <= 1'b0;
            rej <= 1'b0;
            unique case (sbt_action_t'(req.action))
              ACT_CLEAR: begin
                count <= '0;
                state <= ST_FINISH;
              end
              ACT_ADD: begin
                if (count >= CW'(CAP)) begin
                  rej   <= 1'b1;
                  state <= ST_FINISH;
                end else if (req.address == '0) begin
                  state <= ST_FINISH;
                end else begin
                  state <= ST_SRCH_RD;
                end
              end
              default: begin
                state <= (req.address == '0) ? ST_FINISH : ST_SRCH_RD;
              end
            endcase
          end
        end
        ST_SRCH_RD: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= ST_SRCH_CMP;
          end else if (act == ACT_ADD) begin
            ptr   <= count;
            state <= ST_SHIFT_RD;
          end else if (lo == '0) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_PREV_CMP;
          end
        end
        ST_SRCH_CMP: begin
          // upper bound: step past entries not above the key
          if (mem_rdata <= key) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= ST_SRCH_RD;
        end
        ST_PREV_CMP: begin
          if (mem_rdata == key) begin
            if (act == ACT_LOOKUP) begin
              hit   <= 1'b1;
              state <= ST_FINISH;
            end else begin
              ptr   <= lo - CW'(1);
              state <= ST_SHIFT_RD;
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_SHIFT_RD: begin
          if (act == ACT_ADD) begin
            if (ptr == lo) begin
              count <= count + CW'(1);
              state <= ST_FINISH;
            end else begin
              state <= ST_SHIFT_WR;
            end
          end else if (ptr == count - CW'(1)) begin
            count <= count - CW'(1);
            state <= ST_FINISH;
          end else begin
            state <= ST_SHIFT_WR;
          end
        end
        ST_SHIFT_WR: begin
          ptr   <= (act == ACT_ADD) ? ptr - CW'(1) : ptr + CW'(1);
          state <= ST_SHIFT_RD;
        end
        ST_FINISH: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign count_wide      = {4'b0, count};
  assign res.hit         = hit;
  assign res.entry_count = count_wide[3:0];
  assign res.rejected    = rej;

  sbt_mem #(
    .DEPTH(CAP),
    .AW   (CW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sbt_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_load),
    .result(res),
    .free  (res_free),
    .rsp   (rsp)
  );

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAP))
    else $error("entry count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != ST_IDLE)
    else $error("accepted word did not start work");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_SHIFT_WR || state == ST_SHIFT_RD))
    else $error("memory write outside shift states");

  a_no_rw_same: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write of one entry in one cycle");

  a_reject_add: assert property (@(posedge clk) disable iff (rst)
    res_load && rej |-> act == ACT_ADD && count == CW'(CAP))
    else $error("reject outside full add");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted breakpoint table
// ----------------------------------------------------------------------------
// a short directed list covers the empty table, duplicates, zero addresses,
// the full table and clear. It is followed by random phases that draw most
// addresses from a small per-phase pool, so lookups hit and deletes find
// their copies. Every accepted request word is run through a local table
// model. Each result word is compared field by field with the oldest
// prediction. Both channels idle in random bursts, and the result side once
// holds off long enough to back the table up into its request port.
// ----------------------------------------------------------------------------
module tb_top;
  import sbt_pkg::*;

  localparam int Slots      = 16;
  localparam int Capacity   = Slots - 1;
  localparam int RandWords  = 600;
  localparam int QuietTail  = 80;
  localparam int HoldCycles = 400;

  typedef struct packed {
    sbt_action_t            action;
    logic [AddrWidth-1:0]   address;
  } bp_word_t;

  logic clk;
  logic rst;

  sbt_in_if  req_if ();
  sbt_out_if rsp_if ();

  sorted_breakpoint_table #(
    .TABLE_SLOTS(Slots)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // local copy of the table
  logic [AddrWidth-1:0] bp_entries [Capacity];
  int                   bp_fill;

  bp_word_t    pending_words[$];
  sbt_result_t predicted_results[$];

  logic req_taken;
  logic long_hold;
  int   send_gap, send_odds, send_window;
  int   recv_gap, recv_odds, recv_window;
  int   n_accepted, n_checked, n_errors;
  int   n_hits, n_rejects, n_clears, peak_fill;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // models one request word against the local table, returns the result word
  function automatic sbt_result_t apply_table_op(sbt_action_t act,
                                                 logic [AddrWidth-1:0] addr);
    sbt_result_t r;
    int          pos;
    r   = '0;
    pos = -1;
    case (act)
      ACT_LOOKUP: begin
        for (int i = 0; i < bp_fill; i++)
          if (addr != '0 && bp_entries[i] == addr) r.hit = 1'b1;
      end
      ACT_ADD: begin
        if (bp_fill >= Capacity) begin
          r.rejected = 1'b1;
        end else if (addr != '0) begin
          pos = bp_fill;
          while (pos > 0 && bp_entries[pos-1] > addr) begin
            bp_entries[pos] = bp_entries[pos-1];
            pos--;
          end
          bp_entries[pos] = addr;
          bp_fill++;
        end
      end
      ACT_DELETE: begin
        for (int i = 0; i < bp_fill; i++)
          if (addr != '0 && bp_entries[i] == addr) pos = i;
        if (pos >= 0) begin
          for (int i = pos; i < bp_fill - 1; i++) bp_entries[i] = bp_entries[i+1];
          bp_fill--;
        end
      end
      default: begin
        bp_fill = 0;
      end
    endcase
    r.entry_count = CountWidth'(bp_fill);
    return r;
  endfunction

  task automatic queue_word(sbt_action_t act, logic [AddrWidth-1:0] addr);
    bp_word_t w;
    w.action  = act;
    w.address = addr;
    pending_words.push_back(w);
  endtask

  // request side: a word once offered stays up until taken
  always @(negedge clk) begin
    bp_word_t w;
    logic     v;
    if (!rst) begin
      v = req_if.valid && !req_taken;
      if (send_window == 0) begin
        send_window = $urandom_range(40, 160);
        send_odds   = $urandom_range(0, 3);
      end else begin
        send_window--;
      end
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > QuietTail && send_odds != 0 &&
                     $urandom_range(0, send_odds * 3) == 0) begin
          send_gap = $urandom_range(0, 13);
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          req_if.action  <= w.action;
          req_if.address <= w.address;
          v = 1'b1;
        end
      end
      req_if.valid <= v;
    end
  end

  // result side
  always @(negedge clk) begin
    logic rdy;
    if (!rst) begin
      rdy = 1'b1;
      if (recv_window == 0) begin
        recv_window = $urandom_range(40, 160);
        recv_odds   = $urandom_range(0, 3);
      end else begin
        recv_window--;
      end
      if (long_hold) begin
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (pending_words.size() > QuietTail && recv_odds != 0 &&
                   $urandom_range(0, recv_odds * 3) == 0) begin
        recv_gap = $urandom_range(0, 13);
        rdy      = 1'b0;
      end
      rsp_if.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    sbt_result_t want;
    sbt_result_t got;
    req_taken = 1'b0;
    if (!rst) begin
      req_taken = req_if.valid && req_if.ready;
      if (req_taken) begin
        want = apply_table_op(sbt_action_t'(req_if.action), req_if.address);
        predicted_results.push_back(want);
        n_accepted++;
        if (bp_fill > peak_fill) peak_fill = bp_fill;
        if (want.hit) n_hits++;
        if (want.rejected) n_rejects++;
        if (sbt_action_t'(req_if.action) == ACT_CLEAR) n_clears++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.hit         = rsp_if.hit;
        got.entry_count = rsp_if.entry_count;
        got.rejected    = rsp_if.rejected;
        if (predicted_results.size() == 0) begin
          $error("result word with nothing pending: hit=%0b count=%0d rejected=%0b",
                 got.hit, got.entry_count, got.rejected);
          n_errors++;
        end else begin
          want = predicted_results.pop_front();
          n_checked++;
          if (got.hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, got.hit);
            n_errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   got.entry_count);
            n_errors++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
            n_errors++;
          end
        end
      end
    end
  end

  // one long receiver hold-off while requests keep coming
  initial begin
    long_hold = 1'b0;
    while (n_accepted < 200) @(posedge clk);
    long_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    logic [AddrWidth-1:0] pool [8];
    int                   add_pct;
    int                   r;
    logic [AddrWidth-1:0] a;
    sbt_action_t          act;

    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.action  = ACT_LOOKUP;
    req_if.address = '0;
    rsp_if.ready   = 1'b0;
    req_taken      = 1'b0;
    bp_fill        = 0;
    send_gap = 0; send_odds = 0; send_window = 0;
    recv_gap = 0; recv_odds = 0; recv_window = 0;
    n_accepted = 0; n_checked = 0; n_errors = 0;
    n_hits = 0; n_rejects = 0; n_clears = 0; peak_fill = 0;

    // directed: empty table, zero address, duplicates, absent delete
    queue_word(ACT_LOOKUP, 16'h0000);
    queue_word(ACT_ADD,    16'h0000);
    queue_word(ACT_ADD,    16'hFFFF);
    queue_word(ACT_ADD,    16'h0001);
    queue_word(ACT_ADD,    16'h0001);
    queue_word(ACT_LOOKUP, 16'h0001);
    queue_word(ACT_LOOKUP, 16'h0000);
    queue_word(ACT_DELETE, 16'h0001);
    queue_word(ACT_LOOKUP, 16'h0001);
    queue_word(ACT_DELETE, 16'h5A5A);
    queue_word(ACT_DELETE, 16'h0000);
    // fill to capacity out of order, then add to the full table
    for (int i = 0; i < Capacity - 2; i++)
      queue_word(ACT_ADD, AddrWidth'((i * 16'h3A1D) ^ 16'h8000));
    queue_word(ACT_ADD,    16'h0000);
    queue_word(ACT_ADD,    16'h4000);
    queue_word(ACT_LOOKUP, 16'hFFFF);
    queue_word(ACT_CLEAR,  16'hFFFF);

    // random phases, each with its own address pool and add bias
    for (int n = 0; n < RandWords; n++) begin
      if (n % 50 == 0) begin
        add_pct = $urandom_range(20, 60);
        foreach (pool[k]) pool[k] = AddrWidth'($urandom_range(1, 65535));
        if ($urandom_range(0, 1) == 0) pool[0] = 16'h0001;
        else pool[0] = 16'hFFFF;
      end
      r = $urandom_range(0, 99);
      if (r < 2) act = ACT_CLEAR;
      else if (r < 2 + add_pct) act = ACT_ADD;
      else if (r < 2 + add_pct + (98 - add_pct) / 2) act = ACT_LOOKUP;
      else act = ACT_DELETE;
      r = $urandom_range(0, 9);
      if (r == 0) a = '0;
      else if (r < 3) a = AddrWidth'($urandom_range(0, 65535));
      else a = pool[$urandom_range(0, 7)];
      queue_word(act, a);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || req_if.valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d predicted result words never arrived", predicted_results.size());
      n_errors++;
    end

    $display("tb_top: %0d request words, %0d results checked, %0d errors",
             n_accepted, n_checked, n_errors);
    $display("tb_top: %0d lookup hits, %0d full-table rejects, %0d clears, peak fill %0d",
             n_hits, n_rejects, n_clears, peak_fill);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sbt_pkg.sv
src/sbt_if.sv
src/sbt_mem.sv
src/sbt_out_reg.sv
src/sorted_breakpoint_table.sv
tb/tb_top.sv
